@@ src/prbg_pkg.sv @@
// Shared types, constants and glyph tables of the progress bar glyph renderer.
`timescale 1ns / 1ps
`default_nettype none

package prbg_pkg;

  localparam int unsigned MIDDLE_CELLS_DEF = 3;
  localparam int unsigned GLYPH_ROWS       = 8;
  localparam int unsigned CAP_PIXELS       = 2;
  localparam int unsigned CELL_PIXELS      = 5;
  localparam int unsigned LEVEL_W          = 16;
  localparam logic [6:0]  BAR_START_POS    = 7'h4B;

  typedef enum logic [2:0] {
    SLOT_START = 3'd0,
    SLOT_FULL  = 3'd1,
    SLOT_EMPTY = 3'd2,
    SLOT_PART  = 3'd3,
    SLOT_END   = 3'd4
  } slot_e;

  typedef enum logic {
    KIND_GLYPH = 1'b0,
    KIND_CELL  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    GLYPH_START,
    GLYPH_MID,
    GLYPH_END
  } glyph_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_FILL,
    ST_CHECK,
    ST_EMIT
  } ctl_state_e;

  typedef struct packed {
    logic [15:0] full_scale;
    logic [15:0] level;
    logic        force_req;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    logic [6:0] target;
    logic [2:0] row;
    logic [4:0] pattern;
    logic       last;
  } out_word_t;

  localparam logic [4:0] START_FG [GLYPH_ROWS] =
    '{5'h00, 5'h00, 5'h02, 5'h01, 5'h03, 5'h00, 5'h00, 5'h00};
  localparam logic [4:0] START_BG [GLYPH_ROWS] =
    '{5'h00, 5'h03, 5'h04, 5'h04, 5'h04, 5'h03, 5'h00, 5'h00};
  localparam logic [4:0] MID_FG [GLYPH_ROWS] =
    '{5'h00, 5'h00, 5'h00, 5'h1f, 5'h1f, 5'h00, 5'h00, 5'h00};
  localparam logic [4:0] MID_BG [GLYPH_ROWS] =
    '{5'h00, 5'h1f, 5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00};
  localparam logic [4:0] END_FG [GLYPH_ROWS] =
    '{5'h00, 5'h00, 5'h08, 5'h18, 5'h18, 5'h00, 5'h00, 5'h00};
  localparam logic [4:0] END_BG [GLYPH_ROWS] =
    '{5'h00, 5'h18, 5'h04, 5'h04, 5'h04, 5'h18, 5'h00, 5'h00};

  // Background plus the foreground pixels that are not masked off as empty.
  function automatic logic [4:0] glyph_row(glyph_e g, logic [2:0] row,
                                           logic [2:0] empty_px);
    logic [4:0] fg;
    logic [4:0] bg;
    logic [4:0] mask;
    unique case (g)
      GLYPH_START: begin
        fg = START_FG[row];
        bg = START_BG[row];
      end
      GLYPH_MID: begin
        fg = MID_FG[row];
        bg = MID_BG[row];
      end
      GLYPH_END: begin
        fg = END_FG[row];
        bg = END_BG[row];
      end
      default: begin
        fg = 5'h00;
        bg = 5'h00;
      end
    endcase
    mask = 5'h1f << empty_px;
    return bg | (fg & mask);
  endfunction

endpackage

`default_nettype wire

@@ src/prbg_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module prbg_div import prbg_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 21,
  parameter int unsigned DIVISOR_W  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in the next dividend bit, subtract when it fits.
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

@@ src/prbg_emit.sv @@
// Write sequencer: walks the bar cells and drives the output word register.
`timescale 1ns / 1ps
`default_nettype none

module prbg_emit import prbg_pkg::*; #(
  parameter int unsigned MIDDLE_CELLS = MIDDLE_CELLS_DEF,
  parameter int unsigned FILL_W       = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [FILL_W-1:0] fill_i,
  output logic                   done_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_word_t              out_word_o
);

  localparam int unsigned SegEnd  = MIDDLE_CELLS + 1;
  localparam int unsigned SegW    = $clog2(MIDDLE_CELLS + 2);
  localparam int unsigned RowCntW = $clog2(GLYPH_ROWS + 1);

  logic [SegW-1:0]    seg_q, seg_d;
  logic [RowCntW-1:0] row_q, row_d;
  logic [FILL_W-1:0]  remf_q, remf_d;
  logic               active_q, active_d;
  logic               vld_q, vld_d;
  out_word_t          word_q, word_d;

  logic              is_start, is_end, part, has_rows, cell_now, advance;
  logic [FILL_W-1:0] cap, take;
  slot_e             slot;
  glyph_e            gsel;
  logic [2:0]        empty_px;

  always_comb begin
    is_start = (seg_q == '0);
    is_end   = (seg_q == SegW'(SegEnd));
    cap      = (is_start || is_end) ? FILL_W'(CAP_PIXELS) : FILL_W'(CELL_PIXELS);
    take     = (remf_q < cap) ? remf_q : cap;
    part     = !is_start && !is_end && (remf_q != '0) &&
               (remf_q < FILL_W'(CELL_PIXELS));
    has_rows = is_start || is_end || part;
    cell_now = (row_q == RowCntW'(GLYPH_ROWS)) || !has_rows;
    advance  = active_q && (!vld_q || !out_stall_i);

    if (is_start) begin
      slot     = SLOT_START;
      gsel     = GLYPH_START;
      empty_px = 3'(CAP_PIXELS) - 3'(take);
    end else if (is_end) begin
      slot     = SLOT_END;
      gsel     = GLYPH_END;
      empty_px = 3'(CELL_PIXELS) - 3'(take);
    end else begin
      gsel     = GLYPH_MID;
      empty_px = 3'(CELL_PIXELS) - 3'(remf_q);
      if (remf_q >= FILL_W'(CELL_PIXELS)) begin
        slot = SLOT_FULL;
      end else if (remf_q == '0) begin
        slot = SLOT_EMPTY;
      end else begin
        slot = SLOT_PART;
      end
    end

    seg_d    = seg_q;
    row_d    = row_q;
    remf_d   = remf_q;
    active_d = active_q;
    word_d   = word_q;
    vld_d    = out_stall_i ? vld_q : 1'b0;
    done_o   = 1'b0;

    if (start_i) begin
      seg_d    = '0;
      row_d    = '0;
      remf_d   = fill_i;
      active_d = 1'b1;
    end else if (advance) begin
      vld_d = 1'b1;
      if (cell_now) begin
        // Cell write closes the segment; consume its pixels.
        word_d.kind    = KIND_CELL;
        word_d.target  = BAR_START_POS + 7'(seg_q);
        word_d.row     = 3'd0;
        word_d.pattern = 5'(slot);
        word_d.last    = is_end;
        remf_d = remf_q - take;
        seg_d  = seg_q + SegW'(1);
        row_d  = '0;
        if (is_end) begin
          active_d = 1'b0;
          done_o   = 1'b1;
        end
      end else begin
        word_d.kind    = KIND_GLYPH;
        word_d.target  = 7'(slot);
        word_d.row     = 3'(row_q);
        word_d.pattern = glyph_row(gsel, 3'(row_q), empty_px);
        word_d.last    = 1'b0;
        row_d = row_q + RowCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      vld_q    <= 1'b0;
      seg_q    <= '0;
      row_q    <= '0;
    end else begin
      active_q <= active_d;
      vld_q    <= vld_d;
      seg_q    <= seg_d;
      row_q    <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remf_q <= remf_d;
    word_q <= word_d;
  end

  assign out_valid_o = vld_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

@@ src/lcd_progress_bar_glyph_render_top.sv @@
// Top level of the progress bar glyph renderer: scaling control and fill state.
//
//   channel  dir  handshake              word
//   in       in   in_valid_i/in_stall_o   in_word_t  (full_scale, level, force_req)
//   out      out  out_valid_o/out_stall_i out_word_t (kind, target, row, pattern, last)
//
// A word is taken while the block is idle; the block then stalls its input until the
// redraw is fully handed to the output register. A nonzero full scale costs one pass
// of the shared bit-serial divider: level over the step size full/len (a reciprocal
// multiply) at or above the bar length, level*len/full below it. Zero full scale
// skips the divider. A check state follows; a redraw then emits up to 29 writes,
// held while the output stalls. Reset clears the last fill to zero and leaves the
// output empty.
`timescale 1ns / 1ps
`default_nettype none

module lcd_progress_bar_glyph_render_top import prbg_pkg::*; #(
  parameter int unsigned MIDDLE_CELLS = MIDDLE_CELLS_DEF
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  // Bar length in pixels: two caps and the middle cells.
  localparam int unsigned FillMax    = 2 * CAP_PIXELS + CELL_PIXELS * MIDDLE_CELLS;
  localparam int unsigned FillW      = $clog2(FillMax + 1);
  localparam int unsigned DividendW  = LEVEL_W + FillW;
  localparam int unsigned DivisorW   = LEVEL_W;
  // Reciprocal of the bar length, exact for every 16-bit full scale.
  localparam int unsigned RecipShift = LEVEL_W + $clog2(FillMax);
  localparam int unsigned ProdW      = LEVEL_W + RecipShift;
  localparam logic [RecipShift-1:0] RecipMul = RecipShift'(
    ((64'd1 << RecipShift) + 64'(FillMax) - 64'd1) / 64'(FillMax));

  ctl_state_e state_q, state_d;
  logic               force_q, force_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [FillW-1:0]   prev_q, prev_d;

  logic                 div_start, div_done;
  logic [DividendW-1:0] div_dividend, div_quotient;
  logic [DivisorW-1:0]  div_divisor;
  logic [FillW-1:0]     fill_sat;
  logic [ProdW-1:0]     step_prod;
  logic [DivisorW-1:0]  step_size;

  logic emit_start, emit_done;
  logic in_accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Step size per pixel: full/len by multiplying with the reciprocal.
  assign step_prod = ProdW'(in_word_i.full_scale) * ProdW'(RecipMul);
  assign step_size = step_prod[ProdW-1:RecipShift];

  // Clamp the divider result to the bar length.
  assign fill_sat = (div_quotient > DividendW'(FillMax)) ? FillW'(FillMax)
                                                         : div_quotient[FillW-1:0];

  always_comb begin
    state_d      = state_q;
    force_d      = force_q;
    fill_d       = fill_q;
    prev_d       = prev_q;
    div_start    = 1'b0;
    div_dividend = DividendW'(in_word_i.level);
    div_divisor  = step_size;
    emit_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          force_d = in_word_i.force_req;
          if (in_word_i.full_scale == '0) begin
            // Zero full scale: empty bar, no division.
            fill_d  = '0;
            state_d = ST_CHECK;
          end else if (in_word_i.full_scale >= LEVEL_W'(FillMax)) begin
            // Large full scale: level over the step size.
            div_start = 1'b1;
            state_d   = ST_DIV_FILL;
          end else begin
            // Small full scale: level*len/full in one pass.
            div_start    = 1'b1;
            div_dividend = DividendW'(in_word_i.level) * DividendW'(FillMax);
            div_divisor  = in_word_i.full_scale;
            state_d      = ST_DIV_FILL;
          end
        end
      end
      ST_DIV_FILL: begin
        if (div_done) begin
          fill_d  = fill_sat;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Drop the redraw when the fill is unchanged and not forced.
        if (!force_q && (fill_q == prev_q)) begin
          state_d = ST_IDLE;
        end else begin
          prev_d     = fill_q;
          emit_start = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    force_q <= force_d;
    fill_q  <= fill_d;
  end

  prbg_div #(
    .DIVIDEND_W (DividendW),
    .DIVISOR_W  (DivisorW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  prbg_emit #(
    .MIDDLE_CELLS (MIDDLE_CELLS),
    .FILL_W       (FillW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (emit_start),
    .fill_i      (fill_q),
    .done_o      (emit_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
